/* rtl/u8sd_pkg.sv */
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CHAR_W   = 22;
    localparam int USED_W   = 3;
    localparam int HELD_MAX = 3;
    localparam int ERR_BIAS = 256;

    // group queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic signed [CHAR_W-1:0] char_value;
        logic                     malformed;
        logic [USED_W-1:0]        bytes_used;
        logic                     run_end;
    } out_beat_t;

    typedef struct packed {
        logic signed [CHAR_W-1:0] char_value;
        logic                     malformed;
        logic [USED_W-1:0]        bytes_used;
    } result_t;

    // All results caused by one input byte: errors for the held bytes
    // (oldest first), then an optional final result.
    typedef struct packed {
        logic [HELD_MAX-1:0][BYTE_W-1:0] err_bytes;
        logic [1:0]                      num_err;
        logic                            has_last;
        result_t                         last;
    } group_t;

    // Sequence length a byte opens: 1..4, or 0 if it cannot open one.
    function automatic logic [2:0] seq_len(input logic [BYTE_W-1:0] b);
        logic [2:0] n;
        if (!b[7]) begin
            n = 3'd1;
        end else if (!b[6]) begin
            n = 3'd0;
        end else if (!b[5]) begin
            n = 3'd2;
        end else if (!b[4]) begin
            n = 3'd3;
        end else if (!b[3]) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic result_t err_result(input logic [BYTE_W-1:0] b);
        result_t r;
        r.char_value = {{(CHAR_W-BYTE_W){1'b0}}, b} - CHAR_W'(ERR_BIAS);
        r.malformed  = 1'b1;
        r.bytes_used = USED_W'(1);
        return r;
    endfunction

endpackage

/* rtl/utf8_stream_decoder_unit.sv */
// Flow: a byte's group enters the queue at the accepting edge; its first result moves
//   into the output register once earlier groups have left and that register is free.
// Throughput: one byte per cycle while the queue has room; a byte that gives k results
//   takes k output beats, and the four-entry group queue absorbs bursts.
// Reset: aresetn low at a clock edge empties the queue, drops the held lead and clears
//   m_valid; the held byte contents are not cleared.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u8sd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output u8sd_pkg::out_beat_t m_data
);
    import u8sd_pkg::*;

    logic   push_valid, push_ready;
    group_t push_group;
    logic   head_valid, pop;
    group_t head_group;

    u8sd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_group (push_group),
        .push_ready (push_ready)
    );

    u8sd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop)
    );

    u8sd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* rtl/u8sd_front.sv */
`timescale 1ns / 1ps

module u8sd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  u8sd_pkg::in_beat_t s_data,
    output logic               push_valid,
    output u8sd_pkg::group_t   push_group,
    input  logic               push_ready
);
    import u8sd_pkg::*;

    logic [HELD_MAX-1:0][BYTE_W-1:0] held_reg, held_next;
    logic [1:0]                      count_reg, count_next;

    logic [BYTE_W-1:0] b;
    logic              eot;
    logic              is_cont;
    logic [2:0]        lead_len;
    logic [2:0]        new_len;
    logic              take_single;
    logic              accept;
    group_t            grp;
    logic [CHAR_W-1:0] cp;

    assign b        = s_data.in_byte;
    assign eot      = s_data.end_of_text;
    assign is_cont  = (b[7:6] == CONT_TAG);
    assign lead_len = seq_len(held_reg[0]);
    assign new_len  = seq_len(b);
    assign s_ready  = push_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        case (lead_len)
            3'd2:    cp = {11'b0, held_reg[0][4:0], b[5:0]};
            3'd3:    cp = {6'b0, held_reg[0][3:0], held_reg[1][5:0], b[5:0]};
            default: cp = {1'b0, held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                           b[5:0]};
        endcase
    end

    always_comb begin
        grp.err_bytes = held_reg;
        grp.num_err   = 2'd0;
        grp.has_last  = 1'b0;
        grp.last      = '0;
        held_next     = held_reg;
        count_next    = count_reg;
        take_single   = 1'b0;

        if (count_reg != 2'd0) begin
            if (is_cont && (({1'b0, count_reg} + 3'd1) == lead_len)) begin
                grp.has_last        = 1'b1;
                grp.last.char_value = cp;
                grp.last.malformed  = 1'b0;
                grp.last.bytes_used = lead_len;
                count_next          = 2'd0;
            end else if (is_cont && !eot) begin
                // hold the continuation and wait for the rest
                case (count_reg)
                    2'd1:    held_next[1] = b;
                    default: held_next[2] = b;
                endcase
                count_next = count_reg + 2'd1;
            end else if (is_cont) begin
                grp.num_err  = count_reg;
                grp.has_last = 1'b1;
                grp.last     = err_result(b);
                count_next   = 2'd0;
            end else begin
                // broken sequence: drop the held bytes as errors, restart at b
                grp.num_err = count_reg;
                count_next  = 2'd0;
                take_single = 1'b1;
            end
        end else begin
            take_single = 1'b1;
        end

        if (take_single) begin
            case (new_len)
                3'd1: begin
                    grp.has_last        = 1'b1;
                    grp.last.char_value = {{(CHAR_W-BYTE_W){1'b0}}, b};
                    grp.last.malformed  = 1'b0;
                    grp.last.bytes_used = USED_W'(1);
                end
                3'd0: begin
                    grp.has_last = 1'b1;
                    grp.last     = err_result(b);
                end
                default: begin
                    if (eot) begin
                        grp.has_last = 1'b1;
                        grp.last     = err_result(b);
                    end else begin
                        held_next[0] = b;
                        count_next   = 2'd1;
                    end
                end
            endcase
        end
    end

    assign push_group = grp;
    assign push_valid = accept && ((grp.num_err != 2'd0) || grp.has_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

/* rtl/u8sd_queue.sv */
`timescale 1ns / 1ps

module u8sd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  u8sd_pkg::group_t push_group,
    output logic             head_valid,
    output u8sd_pkg::group_t head_group,
    input  logic             pop
);
    import u8sd_pkg::*;

    group_t          entries_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_group = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + Q_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

/* rtl/u8sd_back.sv */
`timescale 1ns / 1ps

module u8sd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  u8sd_pkg::group_t    head_group,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output u8sd_pkg::out_beat_t m_data
);
    import u8sd_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic        m_valid_reg;
    out_beat_t   m_data_reg, m_data_next;
    logic [2:0]  total;
    logic        is_last;
    logic        is_err;
    logic        load;
    logic [BYTE_W-1:0] err_byte;
    result_t     cur;

    assign total   = {1'b0, head_group.num_err} + {2'b0, head_group.has_last};
    assign is_last = ({1'b0, pos_reg} == (total - 3'd1));
    assign is_err  = (pos_reg < head_group.num_err);
    assign load    = head_valid && (!m_valid_reg || m_ready);
    assign pop     = load && is_last;

    always_comb begin
        case (pos_reg)
            2'd0:    err_byte = head_group.err_bytes[0];
            2'd1:    err_byte = head_group.err_bytes[1];
            default: err_byte = head_group.err_bytes[2];
        endcase
    end

    always_comb begin
        cur                    = is_err ? err_result(err_byte) : head_group.last;
        m_data_next.char_value = cur.char_value;
        m_data_next.malformed  = cur.malformed;
        m_data_next.bytes_used = cur.bytes_used;
        m_data_next.run_end    = is_last;
        pos_next               = is_last ? 2'd0 : pos_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= 2'd0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                pos_reg     <= pos_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/u8sd_checker.sv */
`timescale 1ns / 1ps

module u8sd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input u8sd_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input u8sd_pkg::out_beat_t m_data
);
    import u8sd_pkg::*;

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // results of one byte leave back to back
    a_run_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_end |=> m_valid)
        else $error("gap inside the results of one byte");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.malformed |->
            m_data.bytes_used == 3'd1 && m_data.char_value[CHAR_W-1] == 1'b1)
        else $error("malformed result with bad value or length");

    a_ascii_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.malformed |->
            m_data.bytes_used != 3'd0 && m_data.bytes_used <= 3'd4 &&
            (m_data.bytes_used != 3'd1 || m_data.char_value[CHAR_W-1:7] == '0))
        else $error("decoded result out of range for its length");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_checker (.*);

/* sim/utf8_stream_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;
    import u8sd_pkg::*;

    localparam int RANDOM_ITEMS = 390;
    localparam int CALM_TAIL    = 50;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int BYTE_SPAN    = 256;

    typedef struct {
        logic [7:0] byte_v;
        bit         eot;
        bit         typed;
        int         want_char;
        bit         want_bad;
    } row_t;

    typedef struct {
        in_beat_t beat;
        bit       typed;
        result_t  want;
    } stim_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    stim_t     byte_plan[$];
    out_beat_t expected_chars[$];
    logic [7:0] held_q [3];
    int        held_n      = 0;
    int        mismatches  = 0;
    int        taken_bytes = 0;
    int        chars_seen  = 0;
    int        cycles      = 0;
    bit        calm        = 1'b0;

    utf8_stream_decoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic note_error(input string msg);
        $display("mismatch at result %0d: %s", chars_seen, msg);
        mismatches++;
    endtask

    function automatic result_t make_result(input int value, input bit bad, input int used);
        result_t r;
        r.char_value = CHAR_W'(value);
        r.malformed  = bad;
        r.bytes_used = USED_W'(used);
        return r;
    endfunction

    function automatic out_beat_t as_beat(input result_t r, input bit last);
        out_beat_t o;
        o.char_value = r.char_value;
        o.malformed  = r.malformed;
        o.bytes_used = r.bytes_used;
        o.run_end    = last;
        return o;
    endfunction

    // 1..4 for a byte that opens a sequence, 0 for one that cannot
    function automatic int lead_len(input logic [7:0] b);
        if (!b[7]) return 1;
        if (!b[6]) return 0;
        if (!b[5]) return 2;
        if (!b[4]) return 3;
        if (!b[3]) return 4;
        return 0;
    endfunction

    // Append the byte to the held window and decode from its oldest byte.
    function automatic int decode_byte(input in_beat_t beat, output result_t res [4]);
        logic [7:0] win [4];
        int len, head, n, avail, cnt, v;
        bit broken;
        len = held_n;
        for (int i = 0; i < len; i++) win[i] = held_q[i];
        win[len] = beat.in_byte;
        len++;
        head = 0;
        cnt = 0;
        while (head < len) begin
            n = lead_len(win[head]);
            avail = len - head;
            broken = 1'b0;
            for (int k = 1; k < n && k < avail; k++) begin
                if (win[head + k][7:6] != 2'b10) broken = 1'b1;
            end
            if (n == 1) begin
                res[cnt] = make_result(int'(win[head]), 1'b0, 1);
                cnt++;
                head++;
            end else if (n == 0 || broken || (avail < n && beat.end_of_text)) begin
                // drop the lead alone; its continuations get decoded on their own
                res[cnt] = make_result(int'(win[head]) - BYTE_SPAN, 1'b1, 1);
                cnt++;
                head++;
            end else if (avail < n) begin
                break;
            end else begin
                v = int'(win[head]) & (n == 2 ? 'h1F : n == 3 ? 'h0F : 'h07);
                for (int k = 1; k < n; k++) v = (v << 6) | int'(win[head + k][5:0]);
                res[cnt] = make_result(v, 1'b0, n);
                cnt++;
                head += n;
            end
        end
        held_n = len - head;
        for (int i = 0; i < held_n; i++) held_q[i] = win[head + i];
        return cnt;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | (8'($urandom) & 8'h3F);
    endfunction

    function automatic logic [7:0] lead_byte(input int n);
        logic [7:0] b;
        if (n == 2) b = 8'hC0 | (8'($urandom) & 8'h1F);
        else if (n == 3) b = 8'hE0 | (8'($urandom) & 8'h0F);
        else b = 8'hF0 | (8'($urandom) & 8'h07);
        return b;
    endfunction

    task automatic plan_byte(input logic [7:0] b, input bit eot);
        stim_t s;
        s.beat.in_byte     = b;
        s.beat.end_of_text = eot;
        s.typed            = 1'b0;
        s.want             = '0;
        byte_plan.push_back(s);
    endtask

    task automatic check_char(input out_beat_t got);
        out_beat_t want;
        if (expected_chars.size() == 0) begin
            note_error($sformatf("unexpected result, char_value %0d", got.char_value));
        end else begin
            want = expected_chars.pop_front();
            if (got.char_value !== want.char_value)
                note_error($sformatf("char_value %0d, want %0d", got.char_value,
                                     want.char_value));
            if (got.malformed !== want.malformed)
                note_error($sformatf("malformed %0b, want %0b", got.malformed, want.malformed));
            if (got.bytes_used !== want.bytes_used)
                note_error($sformatf("bytes_used %0d, want %0d", got.bytes_used,
                                     want.bytes_used));
            if (got.run_end !== want.run_end)
                note_error($sformatf("run_end %0b, want %0b", got.run_end, want.run_end));
        end
        chars_seen++;
    endtask

    // result side: random stalls, one long hold-off, none in the tail
    initial begin : result_side
        int stall_left, hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_char(m_data);
            if (!hold_done && taken_bytes >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : byte_side
        row_t    opening_rows [20];
        stim_t   cur;
        result_t res [4];
        int      n, pick, conts, breaker, gap_left;
        bit      eot_last, cut, pending;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;

        opening_rows = '{
            '{8'h00, 1'b0, 1'b1,    0, 1'b0},
            '{8'h7F, 1'b1, 1'b1,  127, 1'b0},
            '{8'h80, 1'b0, 1'b1, -128, 1'b1},
            '{8'hFF, 1'b0, 1'b1,   -1, 1'b1},
            '{8'hF8, 1'b0, 1'b1,   -8, 1'b1},
            // top of the 4-byte range
            '{8'hF7, 1'b0, 1'b0, 0, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 0, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 0, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 0, 1'b0},
            // overlong NUL
            '{8'hC0, 1'b0, 1'b0, 0, 1'b0},
            '{8'h80, 1'b0, 1'b0, 0, 1'b0},
            // surrogate
            '{8'hED, 1'b0, 1'b0, 0, 1'b0},
            '{8'hA0, 1'b0, 1'b0, 0, 1'b0},
            '{8'h80, 1'b0, 1'b0, 0, 1'b0},
            // lead broken by ASCII
            '{8'hE2, 1'b0, 1'b0, 0, 1'b0},
            '{8'h41, 1'b0, 1'b0, 0, 1'b0},
            // sequence cut by end of text
            '{8'hF0, 1'b0, 1'b0, 0, 1'b0},
            '{8'h9F, 1'b0, 1'b0, 0, 1'b0},
            '{8'h98, 1'b1, 1'b0, 0, 1'b0},
            '{8'hC3, 1'b1, 1'b0, 0, 1'b0}
        };
        foreach (opening_rows[i]) begin
            cur.beat.in_byte     = opening_rows[i].byte_v;
            cur.beat.end_of_text = opening_rows[i].eot;
            cur.typed            = opening_rows[i].typed;
            cur.want             = make_result(opening_rows[i].want_char,
                                               opening_rows[i].want_bad, 1);
            byte_plan.push_back(cur);
        end

        // mostly well-formed text with random content, mixed with broken runs and noise
        while (byte_plan.size() < $size(opening_rows) + RANDOM_ITEMS) begin
            pick     = $urandom_range(0, 99);
            eot_last = ($urandom_range(0, 19) == 0);
            if (pick < 25) begin
                plan_byte(8'($urandom_range(0, 127)), eot_last);
            end else if (pick < 70) begin
                n = (pick < 40) ? 2 : (pick < 55) ? 3 : 4;
                plan_byte(lead_byte(n), 1'b0);
                for (int k = 1; k < n; k++) plan_byte(cont_byte(), eot_last && k == n - 1);
            end else if (pick < 85) begin
                n     = $urandom_range(2, 4);
                conts = $urandom_range(0, n - 2);
                cut   = (pick >= 80);
                plan_byte(lead_byte(n), cut && conts == 0);
                for (int k = 1; k <= conts; k++) plan_byte(cont_byte(), cut && k == conts);
                if (!cut) begin
                    breaker = $urandom_range(0, 191);
                    plan_byte(8'(breaker < 128 ? breaker : breaker + 64), 1'b0);
                end
            end else begin
                plan_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end
        // flush whatever is still held at the close of the run
        byte_plan[byte_plan.size() - 1].beat.end_of_text = 1'b1;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        gap_left = 0;
        pending  = 1'b0;
        while (byte_plan.size() > 0 || pending) begin
            @(posedge aclk);
            if (pending && s_ready) begin
                n = decode_byte(cur.beat, res);
                if (cur.typed) begin
                    expected_chars.push_back(as_beat(cur.want, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++)
                        expected_chars.push_back(as_beat(res[i], i == n - 1));
                end
                taken_bytes++;
                pending = 1'b0;
            end
            if (pending) begin
                // hold the beat until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (byte_plan.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 8) - 1;
                s_valid <= 1'b0;
            end else begin
                cur = byte_plan.pop_front();
                s_valid <= 1'b1;
                s_data  <= cur.beat;
                pending = 1'b1;
            end
            calm = (byte_plan.size() < CALM_TAIL);
        end

        while (expected_chars.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_chars.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_chars.size()));

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
